@@ rtl/core/atgi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atgi_pkg
// shared types, register map and the cordic arctangent table
// ----------------------------------------------------------------------------
package atgi_pkg;

  localparam int AtanEntries = 24;
  localparam int AngleLimit  = 46080;
  localparam int AddrW       = 5;

  localparam logic [AddrW-1:0] REG_BIAS_X    = 5'd0;
  localparam logic [AddrW-1:0] REG_BIAS_Y    = 5'd4;
  localparam logic [AddrW-1:0] REG_BIAS_Z    = 5'd8;
  localparam logic [AddrW-1:0] REG_DEADBAND  = 5'd12;
  localparam logic [AddrW-1:0] REG_STEP_TIME = 5'd16;

  typedef struct packed {
    logic signed [15:0] accel_x;
    logic signed [15:0] accel_y;
    logic signed [15:0] accel_z;
    logic signed [24:0] r_x;
    logic signed [24:0] r_y;
    logic signed [24:0] r_z;
  } item_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] v;
    begin
      case (i)
        5'd0:  v = 22'd2949120;
        5'd1:  v = 22'd1740967;
        5'd2:  v = 22'd919879;
        5'd3:  v = 22'd466945;
        5'd4:  v = 22'd234379;
        5'd5:  v = 22'd117304;
        5'd6:  v = 22'd58666;
        5'd7:  v = 22'd29335;
        5'd8:  v = 22'd14668;
        5'd9:  v = 22'd7334;
        5'd10: v = 22'd3667;
        5'd11: v = 22'd1833;
        5'd12: v = 22'd917;
        5'd13: v = 22'd458;
        5'd14: v = 22'd229;
        5'd15: v = 22'd115;
        5'd16: v = 22'd57;
        5'd17: v = 22'd29;
        5'd18: v = 22'd14;
        5'd19: v = 22'd7;
        5'd20: v = 22'd4;
        5'd21: v = 22'd2;
        5'd22: v = 22'd1;
        default: v = 22'd0;
      endcase
      return v;
    end
  endfunction

endpackage

@@ rtl/core/atgi_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atgi_front
// accepts a sample, removes gyro bias, queues the word for the back end
// ----------------------------------------------------------------------------
module atgi_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   accel_x,
  input  logic signed [15:0]   accel_y,
  input  logic signed [15:0]   accel_z,
  input  logic signed [23:0]   rate_x,
  input  logic signed [23:0]   rate_y,
  input  logic signed [23:0]   rate_z,
  input  logic signed [23:0]   bias_x,
  input  logic signed [23:0]   bias_y,
  input  logic signed [23:0]   bias_z,
  output logic                 q_valid,
  input  logic                 q_ready,
  output atgi_pkg::item_t      q_item
);
  import atgi_pkg::*;

  item_t slot [2];
  logic  wr_ptr, rd_ptr;
  logic  [1:0] count;
  logic  push, pop;

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;
  assign q_valid  = (count != 2'd0);
  assign q_item   = slot[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= '{accel_x, accel_y, accel_z,
        25'(rate_x) - 25'(bias_x), 25'(rate_y) - 25'(bias_y),
        25'(rate_z) - 25'(bias_z)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop) rd_ptr <= ~rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

endmodule

@@ rtl/core/atgi_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// atgi_back
// two iterative cordic lanes and the gyro integrators, with output register
// ----------------------------------------------------------------------------
module atgi_back #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 q_valid,
  output logic                 q_ready,
  input  atgi_pkg::item_t      q_item,
  input  logic [15:0]          deadband,
  input  logic [15:0]          step_time,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   angle_x,
  output logic signed [31:0]   angle_y,
  output logic signed [31:0]   angle_z,
  output logic signed [16:0]   accel_pitch,
  output logic signed [16:0]   accel_roll
);
  import atgi_pkg::*;

  localparam int Steps = (CORDIC_STEPS < AtanEntries) ? CORDIC_STEPS : AtanEntries;
  localparam int CntW  = $clog2(Steps + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ROT = 4'b0010, S_INT = 4'b0100, S_OUT = 4'b1000
  } state_t;

  state_t state;
  logic [CntW-1:0] iter;
  logic [1:0]      lane;
  logic signed [33:0] px, py, rx, ry;
  logic signed [24:0] pz, rz;
  logic pzero, rzero;
  logic signed [24:0] gr [3];
  logic signed [31:0] sum [3];
  logic seeded;
  logic [4:0] iter5;

  assign iter5   = 5'(iter);
  assign q_ready = (state == S_IDLE);

  function automatic logic signed [25:0] rnd_clamp(input logic signed [24:0] z);
    logic signed [25:0] r;
    begin
      r = (26'(z) + 26'sd128) >>> 8;
      if (r > 26'sd46080) r = 26'sd46080;
      if (r < -26'sd46080) r = -26'sd46080;
      return r;
    end
  endfunction

  // gyro integration of one axis per cycle
  logic signed [24:0] r_cur;
  logic [24:0]        r_mag;
  logic signed [24:0] r_eff;
  logic signed [41:0] prod;
  logic signed [33:0] inc;
  logic signed [33:0] base;
  logic signed [33:0] tot;
  logic signed [31:0] sat;
  logic signed [16:0] pitch_v, roll_v;

  assign pitch_v = 17'(rnd_clamp(pz));
  assign roll_v  = 17'(rnd_clamp(rz));

  always_comb begin
    r_cur = gr[lane];
    r_mag = r_cur[24] ? 25'(-r_cur) : r_cur;
    r_eff = (r_mag < 25'(deadband)) ? 25'sd0 : r_cur;
    prod  = 42'(r_eff) * $signed({26'd0, step_time});
    inc   = 34'((prod + 42'sd32768) >>> 16);
    if (!seeded && lane == 2'd0) base = 34'(pzero ? 17'sd0 : pitch_v);
    else if (!seeded && lane == 2'd1) base = 34'(rzero ? 17'sd0 : roll_v);
    else base = 34'(sum[lane]);
    tot = base + inc;
    if (tot > 34'sh7FFFFFFF) sat = 32'sh7FFFFFFF;
    else if (tot < -34'sh80000000) sat = 32'sh80000000;
    else sat = 32'(tot);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      seeded <= 1'b0;
      iter   <= '0;
      lane   <= 2'd0;
      sum[0] <= '0;
      sum[1] <= '0;
      sum[2] <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            logic signed [33:0] x0, y0;
            x0 = 34'(q_item.accel_z) <<< 14;
            y0 = 34'(q_item.accel_x) <<< 14;
            pzero <= (q_item.accel_x == 0) && (q_item.accel_z == 0);
            if (x0 < 0) begin
              px <= y0[33] ? -y0 : y0;
              py <= y0[33] ? x0 : -x0;
              pz <= y0[33] ? -25'sd5898240 : 25'sd5898240;
            end else begin
              px <= x0; py <= y0; pz <= '0;
            end
            y0 = 34'(q_item.accel_y) <<< 14;
            rzero <= (q_item.accel_y == 0) && (q_item.accel_z == 0);
            if (x0 < 0) begin
              rx <= y0[33] ? -y0 : y0;
              ry <= y0[33] ? x0 : -x0;
              rz <= y0[33] ? -25'sd5898240 : 25'sd5898240;
            end else begin
              rx <= x0; ry <= y0; rz <= '0;
            end
            gr[0] <= q_item.r_x;
            gr[1] <= q_item.r_y;
            gr[2] <= q_item.r_z;
            iter  <= '0;
            state <= (Steps == 0) ? S_INT : S_ROT;
          end
        end
        S_ROT: begin
          if (py >= 0) begin
            px <= px + (py >>> iter5);
            py <= py - (px >>> iter5);
            pz <= pz + 25'(atan_entry(iter5));
          end else begin
            px <= px - (py >>> iter5);
            py <= py + (px >>> iter5);
            pz <= pz - 25'(atan_entry(iter5));
          end
          if (ry >= 0) begin
            rx <= rx + (ry >>> iter5);
            ry <= ry - (rx >>> iter5);
            rz <= rz + 25'(atan_entry(iter5));
          end else begin
            rx <= rx - (ry >>> iter5);
            ry <= ry + (rx >>> iter5);
            rz <= rz - 25'(atan_entry(iter5));
          end
          if (iter == CntW'(Steps - 1)) begin
            state <= S_INT;
            lane  <= 2'd0;
          end
          iter <= iter + CntW'(1);
        end
        S_INT: begin
          sum[lane] <= sat;
          if (lane == 2'd2) begin
            seeded      <= 1'b1;
            accel_pitch <= pzero ? 17'sd0 : pitch_v;
            accel_roll  <= rzero ? 17'sd0 : roll_v;
            state       <= S_OUT;
          end
          lane <= (lane == 2'd2) ? 2'd0 : lane + 2'd1;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_valid = (state == S_OUT);
  assign angle_x   = sum[0];
  assign angle_y   = sum[1];
  assign angle_z   = sum[2];

endmodule

@@ rtl/core/accel_tilt_gyro_integrator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// accel_tilt_gyro_integrator
// each sample passes through the cordic rotation, the integration of the
// three axes and the output register; no new sample enters the back end
// until the result is taken, but a two-word queue takes new samples meanwhile
// reset: synchronous, clears angle sums, seed flag and registers to defaults
// ----------------------------------------------------------------------------
module accel_tilt_gyro_integrator #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [4:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic signed [15:0]   accel_x,
  input  logic signed [15:0]   accel_y,
  input  logic signed [15:0]   accel_z,
  input  logic signed [23:0]   rate_x,
  input  logic signed [23:0]   rate_y,
  input  logic signed [23:0]   rate_z,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic signed [31:0]   angle_x,
  output logic signed [31:0]   angle_y,
  output logic signed [31:0]   angle_z,
  output logic signed [16:0]   accel_pitch,
  output logic signed [16:0]   accel_roll
);
  import atgi_pkg::*;

  logic signed [23:0] bias_x, bias_y, bias_z;
  logic [15:0] deadband, step_time;
  logic q_valid, q_ready;
  item_t q_item;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_x    <= '0;
      bias_y    <= '0;
      bias_z    <= '0;
      deadband  <= 16'd3;
      step_time <= 16'd6554;
    end else if (psel && penable && pwrite) begin
      unique case (paddr)
        REG_BIAS_X:    bias_x    <= pwdata[23:0];
        REG_BIAS_Y:    bias_y    <= pwdata[23:0];
        REG_BIAS_Z:    bias_z    <= pwdata[23:0];
        REG_DEADBAND:  deadband  <= pwdata[15:0];
        REG_STEP_TIME: step_time <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      REG_BIAS_X:    prdata = 32'(bias_x);
      REG_BIAS_Y:    prdata = 32'(bias_y);
      REG_BIAS_Z:    prdata = 32'(bias_z);
      REG_DEADBAND:  prdata = 32'(deadband);
      REG_STEP_TIME: prdata = 32'(step_time);
      default:       prdata = '0;
    endcase
  end

  atgi_front u_front (
    .clk, .rst, .in_valid, .in_ready,
    .accel_x, .accel_y, .accel_z, .rate_x, .rate_y, .rate_z,
    .bias_x, .bias_y, .bias_z,
    .q_valid, .q_ready, .q_item
  );

  atgi_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk, .rst, .q_valid, .q_ready, .q_item, .deadband, .step_time,
    .out_valid, .out_ready, .angle_x, .angle_y, .angle_z,
    .accel_pitch, .accel_roll
  );

endmodule
